// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

    localparam int VAL_W = 32;
    localparam int CAP_W = 11;
    localparam int ACT_W = 3;

    localparam logic [VAL_W-1:0] EMPTY_VALUE = {VAL_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK       = 3'd4
    } t_action;

    // shr: take left neighbor, shl: take right neighbor, wr: load value where index == count
    typedef struct packed {
        logic shr;
        logic shl;
        logic wr;
    } t_cell_ctl;

endpackage

// ----- rtl/bdq_cell.sv -----
module bdq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic                          i_clk,
    input  bdq_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                 i_count,
    input  logic [bdq_pkg::VAL_W-1:0]     i_value,
    input  logic [bdq_pkg::VAL_W-1:0]     i_left,
    input  logic [bdq_pkg::VAL_W-1:0]     i_right,
    output logic [bdq_pkg::VAL_W-1:0]     o_data
);

    logic [bdq_pkg::VAL_W-1:0] r_data;
    logic [bdq_pkg::VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.shr) begin
            n_data = i_left;
        end else if (i_ctl.shl) begin
            n_data = i_right;
        end else if (i_ctl.wr && (i_count == CW'(IDX))) begin
            n_data = i_value;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/bdq_chain.sv -----
module bdq_chain #(
    parameter int DEPTH = 1024,
    parameter int CW    = 11
) (
    input  logic                          i_clk,
    input  bdq_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                 i_count,
    input  logic [bdq_pkg::VAL_W-1:0]     i_value,
    output logic [bdq_pkg::VAL_W-1:0]     o_head
);

    logic [bdq_pkg::VAL_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [bdq_pkg::VAL_W-1:0] w_left;
        logic [bdq_pkg::VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        // last cell's right side only matters past the held range
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        bdq_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

// ----- rtl/bounded_double_ended_queue_core.sv -----
// Channel | Handshake                 | Words
// in      | i_in_valid / o_in_ready   | i_action, i_value
// out     | o_out_valid / i_out_ready | o_ok, o_front_value, o_rear_value, o_is_empty, o_is_full
// cfg     | i_cfg_we (no wait)        | i_cfg_wdata (capacity)
//
// One word per cycle while results drain: an accepted action updates the cell chains it
// touches, and the result is read from the chain heads the cycle after acceptance.
// Two chains hold the entries in opposite order so front and back are both a head cell.
// Synchronous active-low reset empties the queue and sets capacity to 1024; cells keep data.
// While a result waits for i_out_ready, a new word is taken only in the cycle it drains.
module bounded_double_ended_queue_core #(
    parameter int DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bdq_pkg::ACT_W-1:0]         i_action,
    input  logic signed [bdq_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic signed [bdq_pkg::VAL_W-1:0]  o_front_value,
    output logic signed [bdq_pkg::VAL_W-1:0]  o_rear_value,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    input  logic                              i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]         i_cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [bdq_pkg::CAP_W-1:0]   r_cap;
    logic                        r_ok;
    logic                        n_ok;
    logic                        r_out_valid;

    logic                        w_accept;
    logic [MW-1:0]               w_cap_ext;
    logic [MW-1:0]               w_eff_cap;
    logic [MW-1:0]               w_count_ext;
    logic                        w_full;
    logic                        w_empty;
    bdq_pkg::t_cell_ctl          w_ctl_front;
    bdq_pkg::t_cell_ctl          w_ctl_rear;
    logic [bdq_pkg::VAL_W-1:0]   w_front_head;
    logic [bdq_pkg::VAL_W-1:0]   w_rear_head;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cap_ext   = MW'(r_cap);
    assign w_eff_cap   = (w_cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : w_cap_ext;
    assign w_count_ext = MW'(r_count);
    assign w_full      = (w_count_ext >= w_eff_cap);
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_count     = r_count;
        n_ok        = 1'b1;
        w_ctl_front = '0;
        w_ctl_rear  = '0;
        unique case (bdq_pkg::t_action'(i_action))
            bdq_pkg::ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_ok = 1'b0;
                end else begin
                    w_ctl_front.shr = 1'b1;
                    w_ctl_rear.wr   = 1'b1;
                    n_count         = r_count + CW'(1);
                end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_ok = 1'b0;
                end else begin
                    w_ctl_rear.shr = 1'b1;
                    w_ctl_front.wr = 1'b1;
                    n_count        = r_count + CW'(1);
                end
            end
            bdq_pkg::ACT_POP_FRONT: begin
                if (w_empty) begin
                    n_ok = 1'b0;
                end else begin
                    w_ctl_front.shl = 1'b1;
                    n_count         = r_count - CW'(1);
                end
            end
            bdq_pkg::ACT_POP_BACK: begin
                if (w_empty) begin
                    n_ok = 1'b0;
                end else begin
                    w_ctl_rear.shl = 1'b1;
                    n_count        = r_count - CW'(1);
                end
            end
            default: begin
                // peek and unused codes
            end
        endcase
        if (!w_accept) begin
            n_count     = r_count;
            w_ctl_front = '0;
            w_ctl_rear  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= bdq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_ok        <= n_ok;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    bdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_front),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (w_front_head)
    );

    bdq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_rear_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl_rear),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (w_rear_head)
    );

    // queue contents are frozen while a result is pending, so the heads are the result
    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_front_value = w_empty ? bdq_pkg::EMPTY_VALUE : w_front_head;
    assign o_rear_value  = w_empty ? bdq_pkg::EMPTY_VALUE : w_rear_head;
    assign o_is_empty    = w_empty;
    assign o_is_full     = w_full;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_ext <= MW'(DEPTH))
        else $error("entry count above depth");

    a_refused_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full &&
         (i_action == bdq_pkg::ACT_PUSH_FRONT || i_action == bdq_pkg::ACT_PUSH_BACK))
        |=> $stable(r_count))
        else $error("refused push changed the count");

    a_single_entry_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(1)) |-> (w_front_head == w_rear_head))
        else $error("chains disagree on a single entry");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_count) && $stable(r_ok))
        else $error("queue state moved under a pending result");
`endif

endmodule
